### rtl/shg_pkg.sv
// ----------------------------------------------------------------------------
// Spatial hash grid package
// Shared types, sizes, codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package shg_pkg;

    localparam int NUM_CELLS    = 256;
    localparam int BUCKET_DEPTH = 8;
    localparam int MAX_RESULTS  = 64;
    localparam int SPAN_LIMIT   = 4;

    localparam int SLOT_W  = $clog2(NUM_CELLS);
    localparam int DEPTH_W = $clog2(BUCKET_DEPTH);
    localparam int CNT_W   = $clog2(BUCKET_DEPTH + 1);
    localparam int GIDX_W  = $clog2(MAX_RESULTS);
    localparam int GCNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int BID_W   = $clog2(NUM_CELLS * BUCKET_DEPTH);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd1;
    localparam logic [2:0] ST_BUCKET_FULL = 3'd2;
    localparam logic [2:0] ST_OVERFLOW    = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [23:0] box_x;
        logic signed [23:0] box_y;
        logic [22:0]        box_width;
        logic [22:0]        box_height;
        logic [15:0]        object_id;
    } in_item_t;

    typedef struct packed {
        logic [15:0] result_id;
        logic        found;
        logic        last;
        logic [2:0]  status;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_RANGE,
        S_CLEAR, S_SCAN, S_SCAN_END, S_INS, S_GATHER_RD, S_GATHER_WR,
        S_NEXT_CELL, S_SORT_RD, S_SORT_CMP, S_DED_RD, S_DED_CMP,
        S_EMIT_RD, S_EMIT, S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       mul_step;
        logic       mul_first;
        logic       range_calc;
        logic       clear_step;
        logic       scan_start;
        logic       scan_step;
        logic       ins_write;
        logic       claim;
        logic       gath_rd;
        logic       gath_wr;
        logic       next_cell;
        logic       sort_start;
        logic       sort_rd;
        logic       sort_cmp;
        logic       ded_start;
        logic       ded_rd;
        logic       ded_cmp;
        logic       emit_start;
        logic       emit_rd;
        logic       emit_step;
        logic       fin;
        logic [2:0] fin_status;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       too_large;
        logic       clear_done;
        logic       scan_done;
        logic       hit;
        logic       have_free;
        logic       bucket_full;
        logic       gath_more;
        logic       gath_over;
        logic       last_cell;
        logic       gath_empty;
        logic       sort_done;
        logic       sort_shift;
        logic       ded_done;
        logic       emit_last;
    } sts_t;

endpackage

### rtl/shg_datapath.sv
// ----------------------------------------------------------------------------
// Spatial hash grid datapath
// Cell range arithmetic, slot table, bucket memory and gather/sort/dedupe.
// ----------------------------------------------------------------------------
module shg_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  shg_pkg::in_item_t   item,
    input  logic [23:0]         inv,
    input  shg_pkg::ctl_t       ctl,
    output shg_pkg::sts_t       sts,
    output logic                res_valid,
    output shg_pkg::out_item_t  res
);

    shg_pkg::in_item_t item_reg;

    // cell arithmetic: four corner coordinates through one shared multiplier
    logic [1:0]         mul_idx_reg;
    logic signed [24:0] corner;
    logic [24:0]        mag;
    logic [48:0]        prod;
    logic [24:0]        cellmag;
    logic signed [25:0] cellv;
    logic signed [25:0] cval_reg [4];

    always_comb
    begin
        unique case (mul_idx_reg)
            2'd0:    corner = 25'(item_reg.box_x);
            2'd1:    corner = 25'(item_reg.box_y);
            2'd2:    corner = 25'(item_reg.box_x) + 25'($signed({2'b0, item_reg.box_width}));
            default: corner = 25'(item_reg.box_y) + 25'($signed({2'b0, item_reg.box_height}));
        endcase
        mag     = corner[24] ? 25'(-corner) : corner;
        prod    = 49'(mag) * 49'(inv);
        cellmag = prod[48:24];
        cellv   = corner[24] ? -$signed({1'b0, cellmag}) : $signed({1'b0, cellmag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_idx_reg <= '0;
        else if (ctl.load || ctl.mul_first)
            mul_idx_reg <= '0;
        else if (ctl.mul_step)
            mul_idx_reg <= mul_idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            item_reg <= item;
        if (ctl.mul_step)
            cval_reg[mul_idx_reg] <= cellv;
    end

    logic signed [26:0] spanx, spany;
    logic               too_large_reg;
    assign spanx = 27'(cval_reg[2]) - 27'(cval_reg[0]);
    assign spany = 27'(cval_reg[3]) - 27'(cval_reg[1]);

    always_ff @(posedge clk)
    begin
        if (ctl.range_calc)
            too_large_reg <= (spanx > 27'(shg_pkg::SPAN_LIMIT - 1)) ||
                             (spany > 27'(shg_pkg::SPAN_LIMIT - 1));
    end

    // cell walk
    logic [15:0] cx_reg, cy_reg;
    assign sts.last_cell = (cx_reg == cval_reg[2][15:0]) && (cy_reg == cval_reg[3][15:0]);

    always_ff @(posedge clk)
    begin
        if (ctl.range_calc)
        begin
            cx_reg <= cval_reg[0][15:0];
            cy_reg <= cval_reg[1][15:0];
        end
        else if (ctl.next_cell)
        begin
            if (cx_reg == cval_reg[2][15:0])
            begin
                cx_reg <= cval_reg[0][15:0];
                cy_reg <= cy_reg + 16'd1;
            end
            else
                cx_reg <= cx_reg + 16'd1;
        end
    end

    // slot table
    logic [15:0]                     key_x_mem [shg_pkg::NUM_CELLS];
    logic [15:0]                     key_y_mem [shg_pkg::NUM_CELLS];
    logic [shg_pkg::NUM_CELLS-1:0]   in_use_reg;
    logic [shg_pkg::CNT_W-1:0]       count_mem [shg_pkg::NUM_CELLS];
    logic [shg_pkg::NUM_CELLS-1:0]   cnt_valid_reg;
    logic [shg_pkg::SLOT_W:0]        scan_reg;
    logic [shg_pkg::SLOT_W:0]        clr_reg;
    logic [15:0]                     kx_rd_reg, ky_rd_reg;
    logic                            use_rd_reg;
    logic [shg_pkg::SLOT_W-1:0]      rd_slot_reg;
    logic                            rd_valid_reg;
    logic                            hit_reg, free_found_reg;
    logic [shg_pkg::SLOT_W-1:0]      hit_slot_reg, free_slot_reg;
    logic [shg_pkg::SLOT_W-1:0]      slot;
    logic [shg_pkg::CNT_W-1:0]       cnt_rd_reg;
    logic                            cnt_rd_valid;
    logic [shg_pkg::CNT_W-1:0]       slot_cnt;

    assign slot           = hit_reg ? hit_slot_reg : free_slot_reg;
    assign sts.scan_done  = scan_reg[shg_pkg::SLOT_W] && !rd_valid_reg;
    assign sts.hit        = hit_reg;
    assign sts.have_free  = free_found_reg;
    assign sts.clear_done = clr_reg[shg_pkg::SLOT_W];
    assign slot_cnt       = (hit_reg && cnt_rd_valid) ? cnt_rd_reg : '0;
    assign sts.bucket_full = slot_cnt >= shg_pkg::CNT_W'(shg_pkg::BUCKET_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            cnt_valid_reg <= '0;
            scan_reg      <= '0;
            clr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.load)
                clr_reg <= '0;
            else if (ctl.clear_step)
            begin
                cnt_valid_reg[clr_reg[shg_pkg::SLOT_W-1:0]] <= 1'b0;
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctl.scan_start)
            begin
                scan_reg     <= '0;
                rd_valid_reg <= 1'b0;
            end
            else if (ctl.scan_step)
            begin
                rd_valid_reg <= !scan_reg[shg_pkg::SLOT_W];
                if (!scan_reg[shg_pkg::SLOT_W])
                    scan_reg <= scan_reg + 1'b1;
            end
            if (ctl.claim)
                in_use_reg[slot] <= 1'b1;
            if (ctl.ins_write)
                cnt_valid_reg[slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scan_step && !scan_reg[shg_pkg::SLOT_W])
        begin
            kx_rd_reg   <= key_x_mem[scan_reg[shg_pkg::SLOT_W-1:0]];
            ky_rd_reg   <= key_y_mem[scan_reg[shg_pkg::SLOT_W-1:0]];
            use_rd_reg  <= in_use_reg[scan_reg[shg_pkg::SLOT_W-1:0]];
            rd_slot_reg <= scan_reg[shg_pkg::SLOT_W-1:0];
        end
        if (ctl.scan_start)
        begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (ctl.scan_step && rd_valid_reg)
        begin
            if (use_rd_reg && kx_rd_reg == cx_reg && ky_rd_reg == cy_reg && !hit_reg)
            begin
                hit_reg      <= 1'b1;
                hit_slot_reg <= rd_slot_reg;
            end
            if (!use_rd_reg && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= rd_slot_reg;
            end
        end
        if (ctl.claim)
        begin
            key_x_mem[slot] <= cx_reg;
            key_y_mem[slot] <= cy_reg;
        end
    end

    // bucket count: registered read of the selected slot
    logic cnt_ok_reg;
    assign cnt_rd_valid = cnt_ok_reg;
    always_ff @(posedge clk)
    begin
        if (ctl.scan_step)
        begin
            cnt_rd_reg <= count_mem[slot];
            cnt_ok_reg <= cnt_valid_reg[slot];
        end
        if (ctl.ins_write)
            count_mem[slot] <= slot_cnt + 1'b1;
    end

    // bucket memory
    logic [15:0]                bucket_mem [shg_pkg::NUM_CELLS * shg_pkg::BUCKET_DEPTH];
    logic [15:0]                bk_rd_reg;
    logic [shg_pkg::CNT_W-1:0]  bi_reg;
    logic [shg_pkg::BID_W-1:0]  bk_addr;

    assign bk_addr = ctl.ins_write
        ? {slot, slot_cnt[shg_pkg::DEPTH_W-1:0]}
        : {slot, bi_reg[shg_pkg::DEPTH_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (ctl.ins_write)
            bucket_mem[bk_addr] <= item_reg.object_id;
        if (ctl.gath_rd)
            bk_rd_reg <= bucket_mem[bk_addr];
        if (ctl.scan_start)
            bi_reg <= '0;
        else if (ctl.gath_wr)
            bi_reg <= bi_reg + 1'b1;
    end

    // gather buffer, sort and dedupe
    localparam logic [shg_pkg::GCNT_W-1:0] GCNT1 = 1;

    logic [15:0]                g_mem [shg_pkg::MAX_RESULTS];
    logic [shg_pkg::GCNT_W-1:0] n_reg;
    logic [shg_pkg::GCNT_W-1:0] i_reg, j_reg, m_reg;
    logic [15:0]                v_reg, rd_reg;
    logic [shg_pkg::GIDX_W-1:0] g_wa, g_ra;
    logic [15:0]                g_wd;
    logic                       g_we;

    assign sts.gath_more  = hit_reg && (bi_reg < slot_cnt);
    assign sts.gath_over  = n_reg >= shg_pkg::GCNT_W'(shg_pkg::MAX_RESULTS);
    assign sts.gath_empty = n_reg == '0;
    assign sts.sort_done  = i_reg >= n_reg;
    assign sts.sort_shift = (j_reg != '0) && (rd_reg > v_reg);
    assign sts.ded_done   = i_reg >= n_reg;
    assign sts.emit_last  = (i_reg + 1'b1) == m_reg;
    assign sts.cmd        = item_reg.cmd;
    assign sts.too_large  = too_large_reg;

    always_comb
    begin
        g_we = 1'b0;
        g_wa = n_reg[shg_pkg::GIDX_W-1:0];
        g_wd = bk_rd_reg;
        g_ra = '0;
        if (ctl.gath_wr)
            g_we = 1'b1;
        else if (ctl.sort_cmp)
        begin
            g_we = 1'b1;
            g_wa = j_reg[shg_pkg::GIDX_W-1:0];
            g_wd = sts.sort_shift ? rd_reg : v_reg;
        end
        else if (ctl.ded_cmp && (rd_reg != v_reg))
        begin
            g_we = 1'b1;
            g_wa = m_reg[shg_pkg::GIDX_W-1:0];
            g_wd = rd_reg;
        end
        if (ctl.sort_rd)
            g_ra = (j_reg == '0) ? '0 : shg_pkg::GIDX_W'(j_reg - 1'b1);
        else
            g_ra = i_reg[shg_pkg::GIDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            g_mem[g_wa] <= g_wd;
        if (ctl.sort_rd || ctl.ded_rd || ctl.emit_rd || ctl.sort_start)
            rd_reg <= g_mem[g_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            m_reg <= '0;
            v_reg <= '0;
        end
        else
        begin
            if (ctl.load)
                n_reg <= '0;
            else if (ctl.gath_wr)
                n_reg <= n_reg + 1'b1;
            if (ctl.sort_start)
            begin
                i_reg <= GCNT1;
                j_reg <= GCNT1;
            end
            else if (ctl.sort_cmp)
            begin
                if (sts.sort_shift)
                    j_reg <= j_reg - 1'b1;
                else
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= i_reg + 1'b1;
                end
            end
            else if (ctl.ded_start)
            begin
                i_reg <= GCNT1;
                m_reg <= GCNT1;
            end
            else if (ctl.ded_cmp)
            begin
                i_reg <= i_reg + 1'b1;
                if (rd_reg != v_reg)
                begin
                    m_reg <= m_reg + 1'b1;
                    v_reg <= rd_reg;
                end
            end
            else if (ctl.emit_start)
                i_reg <= '0;
            else if (ctl.emit_step)
                i_reg <= i_reg + 1'b1;
            // hold the element being inserted / last kept value
            if (ctl.sort_rd && (j_reg == i_reg))
                v_reg <= g_mem[i_reg[shg_pkg::GIDX_W-1:0]];
            else if (ctl.ded_start)
                v_reg <= g_mem[0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid <= 1'b0;
        else
            res_valid <= ctl.fin || ctl.emit_step;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin)
            res <= '{result_id: 16'd0, found: 1'b0, last: 1'b1, status: ctl.fin_status};
        else if (ctl.emit_step)
            res <= '{result_id: rd_reg, found: 1'b1, last: sts.emit_last,
                     status: shg_pkg::ST_OK};
    end

endmodule

### rtl/shg_controller.sv
// ----------------------------------------------------------------------------
// Spatial hash grid controller
// Sequences cell math, range, clear, slot scan, insert, gather, sort, dedupe and emit steps.
// ----------------------------------------------------------------------------
module shg_controller
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  shg_pkg::sts_t  sts,
    output shg_pkg::ctl_t  ctl,
    output logic           busy
);

    shg_pkg::state_t state_reg, state_next;
    logic            ded_first_reg, emit_first_reg, sort_first_reg;
    logic [2:0]      fin_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= shg_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shg_pkg::S_IDLE:     if (start) state_next = shg_pkg::S_MUL0;
            shg_pkg::S_MUL0:
            begin
                if (sts.cmd == shg_pkg::CMD_CLEAR)
                    state_next = shg_pkg::S_CLEAR;
                else if (sts.cmd == shg_pkg::CMD_INSERT || sts.cmd == shg_pkg::CMD_QUERY)
                    state_next = shg_pkg::S_MUL1;
                else
                    state_next = shg_pkg::S_DONE;
            end
            shg_pkg::S_MUL1:     state_next = shg_pkg::S_MUL2;
            shg_pkg::S_MUL2:     state_next = shg_pkg::S_MUL3;
            shg_pkg::S_MUL3:     state_next = shg_pkg::S_RANGE;
            shg_pkg::S_RANGE:    state_next = shg_pkg::S_SCAN_END;
            shg_pkg::S_SCAN_END:
                state_next = sts.too_large ? shg_pkg::S_DONE : shg_pkg::S_SCAN;
            shg_pkg::S_CLEAR:    if (sts.clear_done) state_next = shg_pkg::S_DONE;
            shg_pkg::S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = (sts.cmd == shg_pkg::CMD_INSERT) ? shg_pkg::S_INS
                                                                 : shg_pkg::S_GATHER_RD;
            end
            shg_pkg::S_INS:
            begin
                if ((!sts.hit && !sts.have_free) || sts.bucket_full || sts.last_cell)
                    state_next = shg_pkg::S_DONE;
                else
                    state_next = shg_pkg::S_NEXT_CELL;
            end
            shg_pkg::S_GATHER_RD:
            begin
                if (!sts.gath_more)
                    state_next = sts.last_cell ? shg_pkg::S_SORT_RD : shg_pkg::S_NEXT_CELL;
                else if (sts.gath_over)
                    state_next = shg_pkg::S_DONE;
                else
                    state_next = shg_pkg::S_GATHER_WR;
            end
            shg_pkg::S_GATHER_WR: state_next = shg_pkg::S_GATHER_RD;
            shg_pkg::S_NEXT_CELL: state_next = shg_pkg::S_SCAN;
            shg_pkg::S_SORT_RD:
            begin
                if (sts.gath_empty)
                    state_next = shg_pkg::S_DONE;
                else if (sort_first_reg)
                    state_next = shg_pkg::S_SORT_RD;
                else if (sts.sort_done)
                    state_next = shg_pkg::S_DED_RD;
                else
                    state_next = shg_pkg::S_SORT_CMP;
            end
            shg_pkg::S_SORT_CMP:  state_next = shg_pkg::S_SORT_RD;
            shg_pkg::S_DED_RD:
            begin
                if (ded_first_reg)
                    state_next = shg_pkg::S_DED_RD;
                else
                    state_next = sts.ded_done ? shg_pkg::S_EMIT_RD : shg_pkg::S_DED_CMP;
            end
            shg_pkg::S_DED_CMP:   state_next = shg_pkg::S_DED_RD;
            shg_pkg::S_EMIT_RD:
                state_next = emit_first_reg ? shg_pkg::S_EMIT_RD : shg_pkg::S_EMIT;
            shg_pkg::S_EMIT:
                state_next = sts.emit_last ? shg_pkg::S_IDLE : shg_pkg::S_EMIT_RD;
            shg_pkg::S_DONE:      state_next = shg_pkg::S_IDLE;
            default:              state_next = shg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ded_first_reg  <= 1'b1;
            emit_first_reg <= 1'b1;
            sort_first_reg <= 1'b1;
        end
        else
        begin
            ded_first_reg  <= !(state_reg == shg_pkg::S_DED_RD ||
                                state_reg == shg_pkg::S_DED_CMP);
            emit_first_reg <= !(state_reg == shg_pkg::S_EMIT_RD ||
                                state_reg == shg_pkg::S_EMIT);
            sort_first_reg <= !(state_reg == shg_pkg::S_SORT_RD ||
                                state_reg == shg_pkg::S_SORT_CMP);
        end
    end

    always_comb
    begin
        ctl = '0;
        busy = state_reg != shg_pkg::S_IDLE;
        unique case (state_reg)
            shg_pkg::S_IDLE:      ctl.load = start;
            shg_pkg::S_MUL0:      ctl.mul_step = 1'b1;
            shg_pkg::S_MUL1:      ctl.mul_step = 1'b1;
            shg_pkg::S_MUL2:      ctl.mul_step = 1'b1;
            shg_pkg::S_MUL3:      ctl.mul_step = 1'b1;
            shg_pkg::S_RANGE:     ctl.range_calc = 1'b1;
            shg_pkg::S_SCAN_END:  ctl.scan_start = 1'b1;
            shg_pkg::S_CLEAR:     ctl.clear_step = 1'b1;
            shg_pkg::S_SCAN:      ctl.scan_step = 1'b1;
            shg_pkg::S_INS:
            begin
                if ((sts.hit || sts.have_free) && !sts.bucket_full)
                begin
                    ctl.ins_write = 1'b1;
                    ctl.claim     = !sts.hit;
                end
            end
            shg_pkg::S_GATHER_RD:
            begin
                ctl.gath_rd = 1'b1;
                if (sts.gath_more && sts.gath_over)
                    ctl.fin = 1'b0;
            end
            shg_pkg::S_GATHER_WR: ctl.gath_wr = 1'b1;
            shg_pkg::S_NEXT_CELL:
            begin
                ctl.next_cell  = 1'b1;
                ctl.scan_start = 1'b1;
            end
            shg_pkg::S_SORT_RD:
            begin
                ctl.sort_start = sort_first_reg;
                ctl.sort_rd    = !sort_first_reg;
            end
            shg_pkg::S_SORT_CMP:  ctl.sort_cmp = 1'b1;
            shg_pkg::S_DED_RD:
            begin
                ctl.ded_start = ded_first_reg;
                ctl.ded_rd    = !ded_first_reg;
            end
            shg_pkg::S_DED_CMP:   ctl.ded_cmp = 1'b1;
            shg_pkg::S_EMIT_RD:
            begin
                ctl.emit_start = emit_first_reg;
                ctl.emit_rd    = !emit_first_reg;
            end
            shg_pkg::S_EMIT:      ctl.emit_step = 1'b1;
            shg_pkg::S_DONE:      ctl.fin = 1'b1;
            default:              ctl = '0;
        endcase
        ctl.mul_first  = state_reg == shg_pkg::S_IDLE;
        ctl.fin_status = shg_pkg::ST_OK;
        if (state_reg == shg_pkg::S_DONE)
            ctl.fin_status = fin_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_status_reg <= shg_pkg::ST_OK;
        else if (state_reg == shg_pkg::S_IDLE)
            fin_status_reg <= shg_pkg::ST_OK;
        else if (state_reg == shg_pkg::S_SCAN_END && sts.too_large)
            fin_status_reg <= shg_pkg::ST_TOO_LARGE;
        else if (state_reg == shg_pkg::S_INS && !sts.hit && !sts.have_free)
            fin_status_reg <= shg_pkg::ST_TABLE_FULL;
        else if (state_reg == shg_pkg::S_INS && sts.bucket_full)
            fin_status_reg <= shg_pkg::ST_BUCKET_FULL;
        else if (state_reg == shg_pkg::S_GATHER_RD && sts.gath_more && sts.gath_over)
            fin_status_reg <= shg_pkg::ST_OVERFLOW;
    end

endmodule

### rtl/spatial_hash_grid_broad_phase_unit.sv
// ----------------------------------------------------------------------------
// Spatial hash grid broad phase unit
// Grid broad phase: insert, query and clear of boxes over a hashed cell table.
//
// channel   direction  handshake
// cmd       in         start / busy
// result    out        res_valid strobe, one cycle, no stall
// cfg       in         cfg_valid / cfg_ready
//
// Each transaction: cell math (multiplies, range check, scan setup), then per
// covered cell a slot scan, an insert or gather-end step and a next-cell step.
// Query adds gather (read, write per id), sort (read, compare per shift or
// placement), dedupe (read, compare per id) and emit (read, emit per result);
// sort, dedupe and emit open with a setup step. Result strobes are registered
// from their final state. Reset empties the slot table and all buckets at once.
// ----------------------------------------------------------------------------
module spatial_hash_grid_broad_phase_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  shg_pkg::in_item_t   item,
    output logic                res_valid,
    output shg_pkg::out_item_t  res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [23:0]         cfg_data
);

    logic [23:0]   inv_reg;
    shg_pkg::ctl_t ctl;
    shg_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_reg <= 24'd65536;
        else if (cfg_valid && cfg_ready)
            inv_reg <= cfg_data;
    end

    shg_controller u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    shg_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .inv       (inv_reg),
        .ctl       (ctl),
        .sts       (sts),
        .res_valid (res_valid),
        .res       (res)
    );

`ifndef SYNTHESIS
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !res_valid || $past(busy))
        else $error("result without a command in flight");
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.found |-> res.status == shg_pkg::ST_OK)
        else $error("hit with error status");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |-> !busy)
        else $error("last result while still busy");
`endif

endmodule
